// ===== rtl/mpq_pkg.sv =====
// ----------------------------------------------------------------------------
// mpq_pkg
// Shared types and codes for the running median store built from two heaps.
// ----------------------------------------------------------------------------
`default_nettype none

package mpq_pkg;

   // request kinds
   localparam logic [1:0] ACT_ADD    = 2'd0;
   localparam logic [1:0] ACT_REMOVE = 2'd1;
   localparam logic [1:0] ACT_PEEK   = 2'd2;

   // request word
   typedef struct packed {
      logic [1:0]         action;
      logic signed [31:0] value;
   } req_type;

   // result word
   typedef struct packed {
      logic signed [31:0] result_value;
      logic               underflow;
      logic               rejected;
      logic [9:0]         element_count;
   } rsp_type;

   // heap select: lower is a max-heap, upper a min-heap
   typedef enum logic {
      HEAP_LOWER = 1'b0,
      HEAP_UPPER = 1'b1
   } heap_sel_type;

   // what to do once the current heap operation ends
   typedef enum logic [1:0] {
      PH_ADD,
      PH_REB,
      PH_FIN,
      PH_REM
   } phase_type;

   // sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ADD_CMP,
      ST_INS_STEP,
      ST_INS_CMP,
      ST_EXT_TOP,
      ST_EXT_LAST,
      ST_EXT_KEY,
      ST_SD_STEP,
      ST_SD_L,
      ST_SD_R,
      ST_SD_DEC,
      ST_PEEK_WAIT,
      ST_NEXT,
      ST_DONE
   } state_type;

   // heap order: true when a belongs above b in the chosen heap
   function automatic logic ranks_above(logic signed [31:0] a, logic signed [31:0] b,
                                        heap_sel_type sel);
      logic r;
      r = (sel == HEAP_LOWER) ? (a > b) : (a < b);
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/mpq_ram.sv =====
// ----------------------------------------------------------------------------
// mpq_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mpq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 512
) (
   input  wire                       clock,
   input  wire                       we,
   input  wire  [$clog2(DEPTH)-1:0]  waddr,
   input  wire  [WIDTH-1:0]          wdata,
   input  wire  [$clog2(DEPTH)-1:0]  raddr,
   output logic [WIDTH-1:0]          rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port and registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

`default_nettype wire

// ===== rtl/median_priority_queue.sv =====
// Each word runs alone: a peek reads the top; a remove extracts the top and sifts down;
// an add sifts the value up, then moves a value across to rebalance when needed.
// The result becomes valid in the same cycle that the next word can be taken;
// a stalled result holds the sequencer in place.
// Throughput: one word at a time; each heap level is a read, compare and write.
// Reset: synchronous, active high; both heaps empty, result register empty.
// ----------------------------------------------------------------------------
// median_priority_queue
// Running median store: lower max-heap and upper min-heap kept in two RAMs,
// walked by one sift sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module median_priority_queue #(
   parameter int HEAP_DEPTH = 512
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_stall,
   input  wire  mpq_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire                   rsp_stall,
   output mpq_pkg::rsp_type      rsp_data
);

   localparam int AW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
   localparam int CW = $clog2(HEAP_DEPTH + 1);
   localparam int LW = AW + 1;
   localparam int TW = CW + 1;
   localparam logic [TW-1:0] CAPACITY = TW'(2 * HEAP_DEPTH - 1);

   // state
   mpq_pkg::state_type    state_ff, state_in;
   mpq_pkg::phase_type    phase_ff, phase_in;
   mpq_pkg::heap_sel_type sel_ff, sel_in;
   logic [CW-1:0]         lower_cnt_ff, lower_cnt_in;
   logic [CW-1:0]         upper_cnt_ff, upper_cnt_in;
   logic [AW-1:0]         idx_ff, idx_in;
   logic [AW-1:0]         best_idx_ff, best_idx_in;
   logic signed [31:0]    key_ff, key_in;
   logic signed [31:0]    head_ff, head_in;
   logic signed [31:0]    best_val_ff, best_val_in;
   mpq_pkg::rsp_type      res_ff, res_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   mpq_pkg::rsp_type      rsp_ff, rsp_in;

   // memory ports
   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   logic signed [31:0]    wr_data;
   logic [AW-1:0]         rd_addr;
   logic [31:0]           lower_rdata, upper_rdata;
   logic signed [31:0]    rdata;

   // derived values
   logic [CW-1:0]         cur_cnt;
   logic [TW-1:0]         total;
   logic [LW-1:0]         left_idx, right_idx;
   logic [AW-1:0]         parent_idx;
   logic [AW-1:0]         tmp_idx;

   mpq_ram #(.WIDTH(32), .DEPTH(HEAP_DEPTH)) u_lower (
      .clock (clock),
      .we    (wr_en && (sel_ff == mpq_pkg::HEAP_LOWER)),
      .waddr (wr_addr),
      .wdata (wr_data),
      .raddr (rd_addr),
      .rdata (lower_rdata)
   );

   mpq_ram #(.WIDTH(32), .DEPTH(HEAP_DEPTH)) u_upper (
      .clock (clock),
      .we    (wr_en && (sel_ff == mpq_pkg::HEAP_UPPER)),
      .waddr (wr_addr),
      .wdata (wr_data),
      .raddr (rd_addr),
      .rdata (upper_rdata)
   );

   // read data of the heap being worked on
   assign rdata     = (sel_ff == mpq_pkg::HEAP_LOWER) ? lower_rdata : upper_rdata;
   assign cur_cnt   = (sel_ff == mpq_pkg::HEAP_LOWER) ? lower_cnt_ff : upper_cnt_ff;
   assign total     = TW'(lower_cnt_ff) + TW'(upper_cnt_ff);
   assign left_idx  = {idx_ff, 1'b1};
   assign right_idx = left_idx + LW'(1);
   assign tmp_idx   = idx_ff - AW'(1);
   assign parent_idx = tmp_idx >> 1;

   assign req_stall = (state_ff != mpq_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mpq_pkg::ST_IDLE;
         lower_cnt_ff <= '0;
         upper_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lower_cnt_ff <= lower_cnt_in;
         upper_cnt_ff <= upper_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      phase_ff    <= phase_in;
      sel_ff      <= sel_in;
      idx_ff      <= idx_in;
      best_idx_ff <= best_idx_in;
      key_ff      <= key_in;
      head_ff     <= head_in;
      best_val_ff <= best_val_in;
      res_ff      <= res_in;
      rsp_ff      <= rsp_in;
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      sel_in       = sel_ff;
      lower_cnt_in = lower_cnt_ff;
      upper_cnt_in = upper_cnt_ff;
      idx_in       = idx_ff;
      best_idx_in  = best_idx_ff;
      key_in       = key_ff;
      head_in      = head_ff;
      best_val_in  = best_val_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      wr_en        = 1'b0;
      wr_addr      = idx_ff;
      wr_data      = key_ff;
      rd_addr      = '0;

      unique case (state_ff)
         mpq_pkg::ST_IDLE: begin
            res_in = '0;
            if (req_valid) begin
               key_in = req_data.value;
               state_in = mpq_pkg::ST_DONE;
               unique case (req_data.action) inside
                  mpq_pkg::ACT_ADD: begin
                     phase_in = mpq_pkg::PH_ADD;
                     if (total >= CAPACITY) begin
                        res_in.rejected = 1'b1;
                     end else if (upper_cnt_ff != '0) begin
                        sel_in   = mpq_pkg::HEAP_UPPER;
                        state_in = mpq_pkg::ST_ADD_CMP;
                     end else begin
                        sel_in       = mpq_pkg::HEAP_LOWER;
                        idx_in       = AW'(lower_cnt_ff);
                        lower_cnt_in = lower_cnt_ff + CW'(1);
                        state_in     = mpq_pkg::ST_INS_STEP;
                     end
                  end
                  mpq_pkg::ACT_REMOVE, mpq_pkg::ACT_PEEK: begin
                     phase_in = mpq_pkg::PH_REM;
                     sel_in = (lower_cnt_ff >= upper_cnt_ff) ? mpq_pkg::HEAP_LOWER
                                                             : mpq_pkg::HEAP_UPPER;
                     if (total == '0) begin
                        res_in.underflow    = 1'b1;
                        res_in.result_value = -32'sd1;
                     end else if (req_data.action == mpq_pkg::ACT_REMOVE) begin
                        state_in = mpq_pkg::ST_EXT_TOP;
                     end else begin
                        state_in = mpq_pkg::ST_PEEK_WAIT;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         // pick a heap against the upper minimum
         mpq_pkg::ST_ADD_CMP: begin
            if (key_ff > rdata) begin
               sel_in       = mpq_pkg::HEAP_UPPER;
               idx_in       = AW'(upper_cnt_ff);
               upper_cnt_in = upper_cnt_ff + CW'(1);
            end else begin
               sel_in       = mpq_pkg::HEAP_LOWER;
               idx_in       = AW'(lower_cnt_ff);
               lower_cnt_in = lower_cnt_ff + CW'(1);
            end
            state_in = mpq_pkg::ST_INS_STEP;
         end

         // sift up: fetch parent of the hole
         mpq_pkg::ST_INS_STEP: begin
            if (idx_ff == '0) begin
               wr_en    = 1'b1;
               state_in = mpq_pkg::ST_NEXT;
            end else begin
               rd_addr  = parent_idx;
               state_in = mpq_pkg::ST_INS_CMP;
            end
         end

         mpq_pkg::ST_INS_CMP: begin
            wr_en = 1'b1;
            if (mpq_pkg::ranks_above(key_ff, rdata, sel_ff)) begin
               wr_data  = rdata;
               idx_in   = parent_idx;
               state_in = mpq_pkg::ST_INS_STEP;
            end else begin
               state_in = mpq_pkg::ST_NEXT;
            end
         end

         // extract: read the top, shrink the count
         mpq_pkg::ST_EXT_TOP: begin
            if (sel_ff == mpq_pkg::HEAP_LOWER) begin
               lower_cnt_in = lower_cnt_ff - CW'(1);
            end else begin
               upper_cnt_in = upper_cnt_ff - CW'(1);
            end
            state_in = mpq_pkg::ST_EXT_LAST;
         end

         mpq_pkg::ST_EXT_LAST: begin
            head_in = rdata;
            rd_addr = AW'(cur_cnt);
            state_in = (cur_cnt == '0) ? mpq_pkg::ST_NEXT : mpq_pkg::ST_EXT_KEY;
         end

         mpq_pkg::ST_EXT_KEY: begin
            key_in   = rdata;
            idx_in   = '0;
            state_in = mpq_pkg::ST_SD_STEP;
         end

         // sift down: fetch children of the hole
         mpq_pkg::ST_SD_STEP: begin
            if (left_idx >= LW'(cur_cnt)) begin
               wr_en    = 1'b1;
               state_in = mpq_pkg::ST_NEXT;
            end else begin
               rd_addr  = left_idx[AW-1:0];
               state_in = mpq_pkg::ST_SD_L;
            end
         end

         mpq_pkg::ST_SD_L: begin
            best_val_in = rdata;
            best_idx_in = left_idx[AW-1:0];
            if (right_idx < LW'(cur_cnt)) begin
               rd_addr  = right_idx[AW-1:0];
               state_in = mpq_pkg::ST_SD_R;
            end else begin
               state_in = mpq_pkg::ST_SD_DEC;
            end
         end

         mpq_pkg::ST_SD_R: begin
            if (mpq_pkg::ranks_above(rdata, best_val_ff, sel_ff)) begin
               best_val_in = rdata;
               best_idx_in = right_idx[AW-1:0];
            end
            state_in = mpq_pkg::ST_SD_DEC;
         end

         mpq_pkg::ST_SD_DEC: begin
            wr_en = 1'b1;
            if (mpq_pkg::ranks_above(best_val_ff, key_ff, sel_ff)) begin
               wr_data  = best_val_ff;
               idx_in   = best_idx_ff;
               state_in = mpq_pkg::ST_SD_STEP;
            end else begin
               state_in = mpq_pkg::ST_NEXT;
            end
         end

         mpq_pkg::ST_PEEK_WAIT: begin
            res_in.result_value = rdata;
            state_in = mpq_pkg::ST_DONE;
         end

         // heap operation finished: rebalance or wrap up
         mpq_pkg::ST_NEXT: begin
            state_in = mpq_pkg::ST_DONE;
            case (phase_ff)
               mpq_pkg::PH_ADD: begin
                  phase_in = mpq_pkg::PH_REB;
                  if (lower_cnt_ff == upper_cnt_ff + CW'(2)) begin
                     sel_in   = mpq_pkg::HEAP_LOWER;
                     state_in = mpq_pkg::ST_EXT_TOP;
                  end else if (upper_cnt_ff == lower_cnt_ff + CW'(2)) begin
                     sel_in   = mpq_pkg::HEAP_UPPER;
                     state_in = mpq_pkg::ST_EXT_TOP;
                  end
               end
               mpq_pkg::PH_REB: begin
                  phase_in = mpq_pkg::PH_FIN;
                  key_in   = head_ff;
                  state_in = mpq_pkg::ST_INS_STEP;
                  if (sel_ff == mpq_pkg::HEAP_LOWER) begin
                     sel_in       = mpq_pkg::HEAP_UPPER;
                     idx_in       = AW'(upper_cnt_ff);
                     upper_cnt_in = upper_cnt_ff + CW'(1);
                  end else begin
                     sel_in       = mpq_pkg::HEAP_LOWER;
                     idx_in       = AW'(lower_cnt_ff);
                     lower_cnt_in = lower_cnt_ff + CW'(1);
                  end
               end
               mpq_pkg::PH_REM: begin
                  res_in.result_value = head_ff;
               end
               default: begin
               end
            endcase
         end

         // hand the word to the result register
         mpq_pkg::ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in               = res_ff;
               rsp_in.element_count = 10'(total);
               rsp_valid_in         = 1'b1;
               state_in             = mpq_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = mpq_pkg::ST_IDLE;
         end
      endcase
   end

`ifndef NO_ASSERTIONS
   // heaps stay balanced between requests
   a_balanced: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mpq_pkg::ST_IDLE) |->
         (lower_cnt_ff == upper_cnt_ff) || (lower_cnt_ff == upper_cnt_ff + CW'(1)) ||
         (upper_cnt_ff == lower_cnt_ff + CW'(1)))
      else $error("heap sizes out of balance");

   // no heap exceeds its memory
   a_bounds: assert property (@(posedge clock) disable iff (reset)
      (lower_cnt_ff <= CW'(HEAP_DEPTH)) && (upper_cnt_ff <= CW'(HEAP_DEPTH)))
      else $error("heap count beyond depth");

   // an accepted word starts work
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff != mpq_pkg::ST_IDLE))
      else $error("accepted word dropped");

   // underflow only reported on an empty store
   a_under: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.underflow) |-> (rsp_ff.element_count == '0))
      else $error("underflow with stored values");
`endif

endmodule

`default_nettype wire
